FILE: rtl/rvid_pkg.sv
package rvid_pkg;

	// major opcodes
	localparam logic [6:0] OP_R      = 7'b0110011;
	localparam logic [6:0] OP_IMM    = 7'b0010011;
	localparam logic [6:0] OP_LOAD   = 7'b0000011;
	localparam logic [6:0] OP_JALR   = 7'b1100111;
	localparam logic [6:0] OP_SYS    = 7'b1110011;
	localparam logic [6:0] OP_STORE  = 7'b0100011;
	localparam logic [6:0] OP_BRANCH = 7'b1100011;
	localparam logic [6:0] OP_LUI    = 7'b0110111;
	localparam logic [6:0] OP_AUIPC  = 7'b0010111;
	localparam logic [6:0] OP_JAL    = 7'b1101111;

	localparam logic [6:0]  F7_BASE = 7'b0000000;
	localparam logic [6:0]  F7_ALT  = 7'b0100000;
	localparam logic [31:0] U_MASK  = 32'hFFFF_F000;

	// format codes
	localparam logic [2:0] FMT_R = 3'd0;
	localparam logic [2:0] FMT_I = 3'd1;
	localparam logic [2:0] FMT_S = 3'd2;
	localparam logic [2:0] FMT_B = 3'd3;
	localparam logic [2:0] FMT_U = 3'd4;
	localparam logic [2:0] FMT_J = 3'd5;
	localparam logic [2:0] FMT_X = 3'd6;

	// instruction identity codes
	localparam logic [5:0] ID_ADD      = 6'd0;
	localparam logic [5:0] ID_SUB      = 6'd1;
	localparam logic [5:0] ID_SLL      = 6'd2;
	localparam logic [5:0] ID_SLT      = 6'd3;
	localparam logic [5:0] ID_SLTU     = 6'd4;
	localparam logic [5:0] ID_XOR      = 6'd5;
	localparam logic [5:0] ID_SRL      = 6'd6;
	localparam logic [5:0] ID_SRA      = 6'd7;
	localparam logic [5:0] ID_OR       = 6'd8;
	localparam logic [5:0] ID_AND      = 6'd9;
	localparam logic [5:0] ID_ADDI     = 6'd10;
	localparam logic [5:0] ID_SLLI     = 6'd11;
	localparam logic [5:0] ID_SLTI     = 6'd12;
	localparam logic [5:0] ID_SLTIU    = 6'd13;
	localparam logic [5:0] ID_XORI     = 6'd14;
	localparam logic [5:0] ID_SRLI     = 6'd15;
	localparam logic [5:0] ID_SRAI     = 6'd16;
	localparam logic [5:0] ID_ORI      = 6'd17;
	localparam logic [5:0] ID_ANDI     = 6'd18;
	localparam logic [5:0] ID_LB       = 6'd19;
	localparam logic [5:0] ID_LH       = 6'd20;
	localparam logic [5:0] ID_LW       = 6'd21;
	localparam logic [5:0] ID_LBU      = 6'd22;
	localparam logic [5:0] ID_LHU      = 6'd23;
	localparam logic [5:0] ID_JALR     = 6'd24;
	localparam logic [5:0] ID_EBREAK   = 6'd25;
	localparam logic [5:0] ID_ECALL    = 6'd26;
	localparam logic [5:0] ID_SB       = 6'd27;
	localparam logic [5:0] ID_SH       = 6'd28;
	localparam logic [5:0] ID_SW       = 6'd29;
	localparam logic [5:0] ID_BEQ      = 6'd30;
	localparam logic [5:0] ID_BNE      = 6'd31;
	localparam logic [5:0] ID_BLT      = 6'd32;
	localparam logic [5:0] ID_BGE      = 6'd33;
	localparam logic [5:0] ID_BLTU     = 6'd34;
	localparam logic [5:0] ID_BGEU     = 6'd35;
	localparam logic [5:0] ID_LUI      = 6'd36;
	localparam logic [5:0] ID_AUIPC    = 6'd37;
	localparam logic [5:0] ID_JAL      = 6'd38;
	localparam logic [5:0] ID_UNK_R    = 6'd39;
	localparam logic [5:0] ID_UNK_I    = 6'd40;
	localparam logic [5:0] ID_UNK_LOAD = 6'd41;
	localparam logic [5:0] ID_UNK_ENV  = 6'd42;
	localparam logic [5:0] ID_UNK_S    = 6'd43;
	localparam logic [5:0] ID_UNK_B    = 6'd44;
	localparam logic [5:0] ID_UNK      = 6'd45;

	typedef struct packed {
		logic [31:0] instr_word;
		logic [31:0] fetch_pc;
	} req_t;

	typedef struct packed {
		logic [31:0]        out_pc;
		logic [31:0]        out_word;
		logic [6:0]         major_op;
		logic [2:0]         func3;
		logic [6:0]         func7;
		logic [4:0]         dest_reg;
		logic [4:0]         src_reg1;
		logic [4:0]         src_reg2;
		logic signed [31:0] immediate;
		logic [2:0]         format_code;
		logic [5:0]         instr_id;
	} rsp_t;

endpackage

FILE: rtl/rvid_decode.sv
module rvid_decode (
	input  rvid_pkg::req_t req,
	output rvid_pkg::rsp_t rsp
);
	import rvid_pkg::*;

	logic [31:0] w;
	logic [6:0]  op;
	logic [2:0]  f3;
	logic [6:0]  f7_raw;
	logic [6:0]  f7;
	logic [2:0]  fmt;
	logic        shift_imm;
	logic [31:0] imm;
	logic [5:0]  id;

	assign w         = req.instr_word;
	assign op        = w[6:0];
	assign f3        = w[14:12];
	assign f7_raw    = w[31:25];
	assign shift_imm = (op == OP_IMM) && (f3 == 3'd1 || f3 == 3'd5);
	assign f7        = (fmt == FMT_R || shift_imm) ? f7_raw : 7'd0;

	always_comb begin
		unique case (op)
			OP_R:                             fmt = FMT_R;
			OP_IMM, OP_LOAD, OP_JALR, OP_SYS: fmt = FMT_I;
			OP_STORE:                         fmt = FMT_S;
			OP_BRANCH:                        fmt = FMT_B;
			OP_LUI, OP_AUIPC:                 fmt = FMT_U;
			OP_JAL:                           fmt = FMT_J;
			default:                          fmt = FMT_X;
		endcase
	end

	always_comb begin
		unique case (fmt)
			FMT_I: imm = shift_imm ? {27'd0, w[24:20]} : {{20{w[31]}}, w[31:20]};
			FMT_S: imm = {{20{w[31]}}, w[31:25], w[11:7]};
			FMT_B: imm = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			FMT_U: imm = w & U_MASK;
			FMT_J: imm = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			default: imm = 32'd0;
		endcase
	end

	always_comb begin
		unique case (op)
			OP_R: begin
				unique case (f3)
					3'd0: id = (f7_raw == F7_BASE) ? ID_ADD :
						(f7_raw == F7_ALT) ? ID_SUB : ID_UNK_R;
					3'd1: id = ID_SLL;
					3'd2: id = ID_SLT;
					3'd3: id = ID_SLTU;
					3'd4: id = ID_XOR;
					3'd5: id = (f7_raw == F7_BASE) ? ID_SRL :
						(f7_raw == F7_ALT) ? ID_SRA : ID_UNK_R;
					3'd6: id = ID_OR;
					default: id = ID_AND;
				endcase
			end
			OP_IMM: begin
				unique case (f3)
					3'd0: id = ID_ADDI;
					3'd1: id = ID_SLLI;
					3'd2: id = ID_SLTI;
					3'd3: id = ID_SLTIU;
					3'd4: id = ID_XORI;
					3'd5: id = (f7_raw == F7_BASE) ? ID_SRLI :
						(f7_raw == F7_ALT) ? ID_SRAI : ID_UNK_I;
					3'd6: id = ID_ORI;
					default: id = ID_ANDI;
				endcase
			end
			OP_LOAD: begin
				unique case (f3)
					3'd0: id = ID_LB;
					3'd1: id = ID_LH;
					3'd2: id = ID_LW;
					3'd4: id = ID_LBU;
					3'd5: id = ID_LHU;
					default: id = ID_UNK_LOAD;
				endcase
			end
			OP_JALR: id = ID_JALR;
			OP_SYS: begin
				if (f3 == 3'd0) begin
					id = w[20] ? ID_EBREAK : ID_ECALL;
				end else begin
					id = ID_UNK_ENV;
				end
			end
			OP_STORE: begin
				unique case (f3)
					3'd0: id = ID_SB;
					3'd1: id = ID_SH;
					3'd2: id = ID_SW;
					default: id = ID_UNK_S;
				endcase
			end
			OP_BRANCH: begin
				unique case (f3)
					3'd0: id = ID_BEQ;
					3'd1: id = ID_BNE;
					3'd4: id = ID_BLT;
					3'd5: id = ID_BGE;
					3'd6: id = ID_BLTU;
					3'd7: id = ID_BGEU;
					default: id = ID_UNK_B;
				endcase
			end
			OP_LUI:   id = ID_LUI;
			OP_AUIPC: id = ID_AUIPC;
			OP_JAL:   id = ID_JAL;
			default:  id = ID_UNK;
		endcase
	end

	always_comb begin
		rsp.out_pc      = req.fetch_pc;
		rsp.out_word    = w;
		rsp.major_op    = op;
		rsp.func3       = f3;
		rsp.func7       = f7;
		rsp.dest_reg    = w[11:7];
		rsp.src_reg1    = w[19:15];
		rsp.src_reg2    = w[24:20];
		rsp.immediate   = imm;
		rsp.format_code = fmt;
		rsp.instr_id    = id;
	end

endmodule

FILE: rtl/rv32i_instruction_decoder.sv
// rv32i decoder: start is registered into vld_s1, then into vld_s2, which drives the done strobe
// throughput one word per cycle; busy is never raised
// results appear for one cycle only and cannot be held off by the receiver
// arst_n clears the valid flags of both stages; payload registers are not reset
module rv32i_instruction_decoder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rvid_pkg::req_t req,
	output logic           done,
	output rvid_pkg::rsp_t rsp
);
	import rvid_pkg::*;

	// input stage
	req_t req_s1;
	logic vld_s1;
	// decoded result
	rsp_t dec;
	// result stage
	rsp_t rsp_s2;
	logic vld_s2;

	// nothing is kept between words, so a new word is taken every cycle
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	// payload capture, only when a word moves in
	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req;
		end
		if (vld_s1) begin
			rsp_s2 <= dec;
		end
	end

	// field split, format, immediate and identity code
	rvid_decode u_decode (
		.req (req_s1),
		.rsp (dec)
	);

	assign done = vld_s2;
	assign rsp  = rsp_s2;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

	import rvid_pkg::*;

	// func3 values of the base set, named per group
	localparam logic [2:0] F3_ADD  = 3'd0;
	localparam logic [2:0] F3_SLL  = 3'd1;
	localparam logic [2:0] F3_SLT  = 3'd2;
	localparam logic [2:0] F3_SLTU = 3'd3;
	localparam logic [2:0] F3_XOR  = 3'd4;
	localparam logic [2:0] F3_SR   = 3'd5;
	localparam logic [2:0] F3_OR   = 3'd6;
	localparam logic [2:0] F3_AND  = 3'd7;

	localparam logic [2:0] F3_LB  = 3'd0;
	localparam logic [2:0] F3_LH  = 3'd1;
	localparam logic [2:0] F3_LW  = 3'd2;
	localparam logic [2:0] F3_LBU = 3'd4;
	localparam logic [2:0] F3_LHU = 3'd5;

	localparam logic [2:0] F3_SB = 3'd0;
	localparam logic [2:0] F3_SH = 3'd1;
	localparam logic [2:0] F3_SW = 3'd2;

	localparam logic [2:0] F3_BEQ  = 3'd0;
	localparam logic [2:0] F3_BNE  = 3'd1;
	localparam logic [2:0] F3_BLT  = 3'd4;
	localparam logic [2:0] F3_BGE  = 3'd5;
	localparam logic [2:0] F3_BLTU = 3'd6;
	localparam logic [2:0] F3_BGEU = 3'd7;

	localparam logic [2:0] F3_PRIV = 3'd0;

	// encodings left unused by the base set
	localparam logic [2:0] F3_LOAD_RSVD   = 3'd3;
	localparam logic [2:0] F3_STORE_RSVD  = 3'd5;
	localparam logic [2:0] F3_BRANCH_RSVD = 3'd2;
	localparam logic [2:0] F3_SYS_RSVD    = 3'd1;

	localparam int LATENCY      = 2;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int RANDOM_WORDS = 950;

	localparam logic [6:0] KNOWN_OPS [10] = '{OP_R, OP_IMM, OP_LOAD, OP_JALR, OP_SYS,
		OP_STORE, OP_BRANCH, OP_LUI, OP_AUIPC, OP_JAL};

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	rsp_t pending_decodes[$];
	int   mismatches;
	int   idle_pct;

	rv32i_instruction_decoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// 8 ns period
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// independent decode of one word, bit for bit as the spec defines it
	function automatic rsp_t decode_instr(input req_t r);
		rsp_t        d;
		logic [31:0] w;
		logic        shift_imm;
		w = r.instr_word;
		d.out_pc   = r.fetch_pc;
		d.out_word = w;
		d.major_op = w[6:0];
		d.func3    = w[14:12];
		d.dest_reg = w[11:7];
		d.src_reg1 = w[19:15];
		d.src_reg2 = w[24:20];

		case (w[6:0])
			OP_R: d.format_code = FMT_R;
			OP_IMM, OP_LOAD, OP_JALR, OP_SYS: d.format_code = FMT_I;
			OP_STORE: d.format_code = FMT_S;
			OP_BRANCH: d.format_code = FMT_B;
			OP_LUI, OP_AUIPC: d.format_code = FMT_U;
			OP_JAL: d.format_code = FMT_J;
			default: d.format_code = FMT_X;
		endcase

		shift_imm = (w[6:0] == OP_IMM) && (w[14:12] == F3_SLL || w[14:12] == F3_SR);
		d.func7 = (d.format_code == FMT_R || shift_imm) ? w[31:25] : F7_BASE;

		case (d.format_code)
			FMT_I: d.immediate = shift_imm ? {27'd0, w[24:20]} : {{20{w[31]}}, w[31:20]};
			FMT_S: d.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
			FMT_B: d.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
			FMT_U: d.immediate = w & U_MASK;
			FMT_J: d.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
			default: d.immediate = '0;
		endcase

		case (w[6:0])
			OP_R: begin
				case (w[14:12])
					F3_ADD: d.instr_id = (d.func7 == F7_BASE) ? ID_ADD :
						(d.func7 == F7_ALT) ? ID_SUB : ID_UNK_R;
					F3_SR: d.instr_id = (d.func7 == F7_BASE) ? ID_SRL :
						(d.func7 == F7_ALT) ? ID_SRA : ID_UNK_R;
					F3_SLL: d.instr_id = ID_SLL;
					F3_SLT: d.instr_id = ID_SLT;
					F3_SLTU: d.instr_id = ID_SLTU;
					F3_XOR: d.instr_id = ID_XOR;
					F3_OR: d.instr_id = ID_OR;
					default: d.instr_id = ID_AND;
				endcase
			end
			OP_IMM: begin
				case (w[14:12])
					F3_ADD: d.instr_id = ID_ADDI;
					F3_SLL: d.instr_id = ID_SLLI;
					F3_SLT: d.instr_id = ID_SLTI;
					F3_SLTU: d.instr_id = ID_SLTIU;
					F3_XOR: d.instr_id = ID_XORI;
					F3_SR: d.instr_id = (d.func7 == F7_BASE) ? ID_SRLI :
						(d.func7 == F7_ALT) ? ID_SRAI : ID_UNK_I;
					F3_OR: d.instr_id = ID_ORI;
					default: d.instr_id = ID_ANDI;
				endcase
			end
			OP_LOAD: begin
				case (w[14:12])
					F3_LB: d.instr_id = ID_LB;
					F3_LH: d.instr_id = ID_LH;
					F3_LW: d.instr_id = ID_LW;
					F3_LBU: d.instr_id = ID_LBU;
					F3_LHU: d.instr_id = ID_LHU;
					default: d.instr_id = ID_UNK_LOAD;
				endcase
			end
			OP_JALR: d.instr_id = ID_JALR;
			OP_SYS: begin
				if (w[14:12] == F3_PRIV) begin
					d.instr_id = w[20] ? ID_EBREAK : ID_ECALL;
				end else begin
					d.instr_id = ID_UNK_ENV;
				end
			end
			OP_STORE: begin
				case (w[14:12])
					F3_SB: d.instr_id = ID_SB;
					F3_SH: d.instr_id = ID_SH;
					F3_SW: d.instr_id = ID_SW;
					default: d.instr_id = ID_UNK_S;
				endcase
			end
			OP_BRANCH: begin
				case (w[14:12])
					F3_BEQ: d.instr_id = ID_BEQ;
					F3_BNE: d.instr_id = ID_BNE;
					F3_BLT: d.instr_id = ID_BLT;
					F3_BGE: d.instr_id = ID_BGE;
					F3_BLTU: d.instr_id = ID_BLTU;
					F3_BGEU: d.instr_id = ID_BGEU;
					default: d.instr_id = ID_UNK_B;
				endcase
			end
			OP_LUI: d.instr_id = ID_LUI;
			OP_AUIPC: d.instr_id = ID_AUIPC;
			OP_JAL: d.instr_id = ID_JAL;
			default: d.instr_id = ID_UNK;
		endcase
		return d;
	endfunction

	// r-type field layout, also used to build the other formats from raw fields
	function automatic logic [31:0] pack_instr(input logic [6:0] op, input logic [2:0] f3,
			input logic [6:0] f7, input logic [4:0] rd, input logic [4:0] rs1,
			input logic [4:0] rs2);
		return {f7, rs2, rs1, f3, rd, op};
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
		end
	endtask

	// result checking and capture of accepted words share one edge-sampled process;
	// the check comes first so a word accepted on this edge is never matched here
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if ($isunknown(done)) begin
				mismatches++;
				$display("%0t ns: done strobe is unknown", $time);
			end else if (done) begin
				if (pending_decodes.size() == 0) begin
					mismatches++;
					$display("%0t ns: result with no word outstanding, actual %h", $time, rsp);
				end else begin
					want = pending_decodes.pop_front();
					check_field("out_pc", want.out_pc, rsp.out_pc);
					check_field("out_word", want.out_word, rsp.out_word);
					check_field("major_op", 32'(want.major_op), 32'(rsp.major_op));
					check_field("func3", 32'(want.func3), 32'(rsp.func3));
					check_field("func7", 32'(want.func7), 32'(rsp.func7));
					check_field("dest_reg", 32'(want.dest_reg), 32'(rsp.dest_reg));
					check_field("src_reg1", 32'(want.src_reg1), 32'(rsp.src_reg1));
					check_field("src_reg2", 32'(want.src_reg2), 32'(rsp.src_reg2));
					check_field("immediate", want.immediate, rsp.immediate);
					check_field("format_code", 32'(want.format_code),
						32'(rsp.format_code));
					check_field("instr_id", 32'(want.instr_id), 32'(rsp.instr_id));
				end
			end
			// a word is taken when start is high and busy low at this edge
			if (start && busy === 1'b0) begin
				pending_decodes.push_back(decode_instr(req));
			end
		end
	end

	// drive one word at the falling edge and hold it until the decoder takes it;
	// an optional idle gap comes first so start only moves once per edge
	task automatic send_word(input logic [31:0] w, input logic [31:0] pc);
		int gap;
		if ($urandom_range(99) < idle_pct) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= '{instr_word: w, fetch_pc: pc};
		@(posedge clk);
		while (busy !== 1'b0) @(posedge clk);
	endtask

	// stop sending and hold off until every decode has come back
	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_decodes.size() != 0) @(posedge clk);
	endtask

	task automatic test_field_extremes();
		send_word(32'h0000_0000, 32'h0000_0000);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// all-ones register fields on a plain add
		send_word(pack_instr(OP_R, F3_ADD, F7_BASE, 5'd31, 5'd31, 5'd31), 32'h8000_0000);
	endtask

	task automatic test_each_format();
		send_word(pack_instr(OP_R, F3_ADD, F7_ALT, 5'd1, 5'd2, 5'd3), 32'h0000_0004);
		// addi with an immediate of minus one
		send_word(pack_instr(OP_IMM, F3_ADD, 7'h7F, 5'd1, 5'd2, 5'h1F), 32'h0000_0008);
		send_word(pack_instr(OP_LOAD, F3_LW, 7'h40, 5'd5, 5'd6, 5'd0), 32'h0000_000C);
		// sw, most negative offset
		send_word(pack_instr(OP_STORE, F3_SW, 7'h40, 5'd0, 5'd7, 5'd8), 32'h0000_0010);
		// beq, most negative offset
		send_word({1'b1, 6'h00, 5'd9, 5'd10, F3_BEQ, 4'h0, 1'b0, OP_BRANCH}, 32'h0000_0014);
		// bgeu, largest positive offset
		send_word({1'b0, 6'h3F, 5'd9, 5'd10, F3_BGEU, 4'hF, 1'b1, OP_BRANCH}, 32'h0000_0018);
		send_word({20'hFFFFF, 5'd11, OP_LUI}, 32'h0000_001C);
		send_word({20'h80001, 5'd12, OP_AUIPC}, 32'h0000_0020);
		// jal, most negative then largest positive offset
		send_word({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OP_JAL}, 32'h0000_0024);
		send_word({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd1, OP_JAL}, 32'hFFFF_FFFC);
		send_word(pack_instr(OP_SYS, F3_PRIV, F7_BASE, 5'd0, 5'd0, 5'd0), 32'h0000_0028);
	endtask

	task automatic test_special_cases();
		// r-type with a func7 that is neither base nor alternate
		send_word(pack_instr(OP_R, F3_ADD, 7'h01, 5'd4, 5'd5, 5'd6), 32'h0000_1000);
		send_word(pack_instr(OP_R, F3_SR, F7_ALT, 5'd4, 5'd5, 5'd6), 32'h0000_1004);
		// sll passes func7 through but ignores it
		send_word(pack_instr(OP_R, F3_SLL, 7'h7F, 5'd4, 5'd5, 5'd6), 32'h0000_1008);
		send_word(pack_instr(OP_IMM, F3_SR, F7_ALT, 5'd4, 5'd5, 5'd31), 32'h0000_100C);
		send_word(pack_instr(OP_IMM, F3_SR, 7'h10, 5'd4, 5'd5, 5'd7), 32'h0000_1010);
		send_word(pack_instr(OP_IMM, F3_SLL, 7'h7F, 5'd4, 5'd5, 5'd31), 32'h0000_1014);
		// jalr decodes whatever func3 holds
		send_word(pack_instr(OP_JALR, F3_AND, 7'h3F, 5'd1, 5'd2, 5'd3), 32'h0000_1018);
		// ebreak with noise in the unchecked bits
		send_word(pack_instr(OP_SYS, F3_PRIV, 7'h55, 5'd3, 5'd9, 5'h01), 32'h0000_101C);
		send_word(pack_instr(OP_SYS, F3_SYS_RSVD, 7'h00, 5'd3, 5'd9, 5'h01), 32'h0000_1020);
		send_word(pack_instr(OP_LOAD, F3_LOAD_RSVD, 7'h00, 5'd1, 5'd2, 5'd3), 32'h0000_1024);
		send_word(pack_instr(OP_STORE, F3_STORE_RSVD, 7'h00, 5'd1, 5'd2, 5'd3), 32'h0000_1028);
		send_word(pack_instr(OP_BRANCH, F3_BRANCH_RSVD, 7'h00, 5'd1, 5'd2, 5'd3), 32'h0000_102C);
	endtask

	// mostly well-formed words with random content, the rest raw noise
	function automatic logic [31:0] random_instr();
		logic [31:0] w;
		w = $urandom;
		if ($urandom_range(99) < 85) begin
			w[6:0] = KNOWN_OPS[$urandom_range(9)];
			if (w[6:0] == OP_R || w[6:0] == OP_IMM) begin
				case ($urandom_range(3))
					0: w[31:25] = F7_BASE;
					1: w[31:25] = F7_ALT;
					default: ;
				endcase
			end else if (w[6:0] == OP_SYS && $urandom_range(1)) begin
				w[14:12] = F3_PRIV;
			end
		end
		return w;
	endfunction

	task automatic test_random(input int count);
		logic [31:0] pc;
		for (int i = 0; i < count; i++) begin
			pc = $urandom;
			if ($urandom_range(1)) pc[1:0] = 2'b00;
			send_word(random_instr(), pc);
			// now and then let the pipe run dry
			if ($urandom_range(99) == 0) wait_drained();
		end
	endtask

	initial begin
		int waited;
		start      = 1'b0;
		req        = '0;
		arst_n     = 1'b0;
		mismatches = 0;
		idle_pct   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_field_extremes();
		test_each_format();
		idle_pct = 46;
		test_special_cases();
		wait_drained();

		// idling phases: none, heavy, moderate
		idle_pct = 0;
		test_random(RANDOM_WORDS / 3);
		idle_pct = 46;
		test_random(RANDOM_WORDS / 3);
		idle_pct = 33;
		test_random(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

		@(negedge clk);
		start <= 1'b0;
		waited = 0;
		while (pending_decodes.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_decodes.size() != 0) begin
			mismatches++;
			$display("%0t ns: %0d decodes never came back", $time, pending_decodes.size());
		end
		// catch any stray strobe after the last word
		repeat (LATENCY + 4) @(posedge clk);

		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
